@@ rtl/core/cas_pkg.sv @@
// Shared types and constants for the chromatic aberration shift block.
package cas_pkg;

    localparam int PIX_W    = 8;
    localparam int SIZE_W   = 9;
    localparam int SHIFT_W  = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 9;

    // Operation codes carried on the request channel
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_DX       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_DY       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_DX      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_DY      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_ALPHA    = 3'd6;

    // Reset values of the configuration registers
    localparam logic [SIZE_W-1:0]         RST_FRAME_WIDTH  = 9'd256;
    localparam logic [SIZE_W-1:0]         RST_FRAME_HEIGHT = 9'd256;
    localparam logic signed [SHIFT_W-1:0] RST_RED_DX       = -6'sd4;
    localparam logic signed [SHIFT_W-1:0] RST_RED_DY       = -6'sd2;
    localparam logic signed [SHIFT_W-1:0] RST_BLUE_DX      = 6'sd4;
    localparam logic signed [SHIFT_W-1:0] RST_BLUE_DY      = 6'sd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLAMP,
        S_ADDR,
        S_READ,
        S_LOAD
    } cas_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic store;    // write the request pixel into the frame memories
        logic capture;  // latch fetch position
        logic clamp;    // register clamped sample coordinates
        logic addr;     // register memory read addresses
        logic read;     // register memory read data
        logic load;     // load the output register
    } cas_cmd_t;

endpackage

@@ rtl/core/cas_if.sv @@
// Request and response channel interfaces.
interface cas_req_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [cas_pkg::PIX_W-1:0]  col;
    logic [cas_pkg::PIX_W-1:0]  row;
    logic [cas_pkg::PIX_W-1:0]  in_red;
    logic [cas_pkg::PIX_W-1:0]  in_green;
    logic [cas_pkg::PIX_W-1:0]  in_blue;
    logic [cas_pkg::PIX_W-1:0]  in_alpha;

    modport source (output valid, op, col, row, in_red, in_green, in_blue, in_alpha,
                    input ready);
    modport sink (input valid, op, col, row, in_red, in_green, in_blue, in_alpha,
                  output ready);
endinterface

interface cas_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [cas_pkg::PIX_W-1:0]  out_col;
    logic [cas_pkg::PIX_W-1:0]  out_row;
    logic [cas_pkg::PIX_W-1:0]  out_red;
    logic [cas_pkg::PIX_W-1:0]  out_green;
    logic [cas_pkg::PIX_W-1:0]  out_blue;
    logic [cas_pkg::PIX_W-1:0]  out_alpha;

    modport source (output valid, out_col, out_row, out_red, out_green, out_blue,
                    out_alpha, input ready);
    modport sink (input valid, out_col, out_row, out_red, out_green, out_blue,
                  out_alpha, output ready);
endinterface

@@ rtl/core/chromatic_aberration_shift.sv @@
// Top level of the chromatic aberration shift block.
//
// Holds one frame of RGBA pixels in on-chip memory and returns shifted output
// pixels from it. A store request (op 0) writes one pixel; stores beyond
// MAX_WIDTH x MAX_HEIGHT are dropped. A fetch request
// (op 1) produces one response: red sampled at (col - red_dx, row - red_dy),
// green at (col, row), blue at (col - blue_dx, row - blue_dy), every
// coordinate clamped to the active frame, and alpha from the green position
// when has_alpha is set, else zero. out_col/out_row echo the request.
// A fetch occupies the block through accept, clamp, address, registered
// memory read and output load; no new request is accepted until it is
// back in idle. The frame is split into three copies (red, green+alpha,
// blue) so the three samples are read in the same cycle.
// The response sits in an output register, so a new request is accepted
// while a finished response waits to be taken; a fetch that finishes while
// the previous response is still waiting holds until it drains.
// Memory contents are undefined after reset: fetch only pixels already stored.
// Configuration (cfg_we/cfg_index/cfg_data) must be written only while idle;
// the block itself does not enforce this. Unknown indexes are ignored.
module chromatic_aberration_shift
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cas_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cas_pkg::CFG_DATA_W-1:0]   cfg_data,
    cas_req_if.sink                          pixel_req,
    cas_rsp_if.source                        pixel_rsp
);

    cas_pkg::cas_cmd_t cmd;

    // sequencing and handshake control
    cas_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel_req.valid),
        .in_op     (pixel_req.op),
        .in_ready  (pixel_req.ready),
        .out_ready (pixel_rsp.ready),
        .out_valid (pixel_rsp.valid),
        .cmd       (cmd)
    );

    // configuration, clamping, frame memories and response register
    cas_datapath
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .col       (pixel_req.col),
        .row       (pixel_req.row),
        .in_red    (pixel_req.in_red),
        .in_green  (pixel_req.in_green),
        .in_blue   (pixel_req.in_blue),
        .in_alpha  (pixel_req.in_alpha),
        .out_col   (pixel_rsp.out_col),
        .out_row   (pixel_rsp.out_row),
        .out_red   (pixel_rsp.out_red),
        .out_green (pixel_rsp.out_green),
        .out_blue  (pixel_rsp.out_blue),
        .out_alpha (pixel_rsp.out_alpha)
    );

endmodule

@@ rtl/core/cas_ctrl.sv @@
// Sequencing controller: request/response handshakes and fetch pipeline steps.
module cas_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_op,
    output logic              in_ready,
    input  logic              out_ready,
    output logic              out_valid,
    output cas_pkg::cas_cmd_t cmd
);

    cas_pkg::cas_state_t state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic                in_xfer;
    logic                out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cas_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        in_xfer     = 1'b0;
        out_free    = !out_valid_reg || out_ready;
        case (state_reg)
            cas_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                in_xfer  = in_valid;
                if (in_xfer)
                begin
                    if (in_op == cas_pkg::OP_FETCH)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = cas_pkg::S_CLAMP;
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                    end
                end
            end
            cas_pkg::S_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = cas_pkg::S_ADDR;
            end
            cas_pkg::S_ADDR:
            begin
                cmd.addr   = 1'b1;
                state_next = cas_pkg::S_READ;
            end
            cas_pkg::S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = cas_pkg::S_LOAD;
            end
            cas_pkg::S_LOAD:
            begin
                // wait here until the output register is free
                if (out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = cas_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cas_pkg::S_IDLE;
            end
        endcase
        out_valid_next = cmd.load || (out_valid_reg && !out_ready);
    end

    assign out_valid = out_valid_reg;

    // Result only loaded when the output register is empty or draining
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == cas_pkg::S_LOAD) && (!out_valid_reg || out_ready))
        else $error("output register overwritten");

    // Accepted fetch enters the clamp step next
    a_fetch_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_op == cas_pkg::OP_FETCH) |=> state_reg == cas_pkg::S_CLAMP)
        else $error("fetch did not start");

    // Fetch steps advance without stalling until the load step
    a_fetch_steps: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cas_pkg::S_CLAMP |=> state_reg == cas_pkg::S_ADDR ##1
        state_reg == cas_pkg::S_READ ##1 state_reg == cas_pkg::S_LOAD)
        else $error("fetch sequence broken");

    // No memory write while a fetch is in flight
    a_no_store_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != cas_pkg::S_IDLE |-> !cmd.store)
        else $error("store during fetch");

endmodule

@@ rtl/core/cas_datapath.sv @@
// Datapath: configuration registers, coordinate clamping, frame memories, output register.
module cas_datapath
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  cas_pkg::cas_cmd_t                 cmd,
    input  logic                              cfg_we,
    input  logic [cas_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cas_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [cas_pkg::PIX_W-1:0]         col,
    input  logic [cas_pkg::PIX_W-1:0]         row,
    input  logic [cas_pkg::PIX_W-1:0]         in_red,
    input  logic [cas_pkg::PIX_W-1:0]         in_green,
    input  logic [cas_pkg::PIX_W-1:0]         in_blue,
    input  logic [cas_pkg::PIX_W-1:0]         in_alpha,
    output logic [cas_pkg::PIX_W-1:0]         out_col,
    output logic [cas_pkg::PIX_W-1:0]         out_row,
    output logic [cas_pkg::PIX_W-1:0]         out_red,
    output logic [cas_pkg::PIX_W-1:0]         out_green,
    output logic [cas_pkg::PIX_W-1:0]         out_blue,
    output logic [cas_pkg::PIX_W-1:0]         out_alpha
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = cas_pkg::PIX_W;
    localparam int SW    = cas_pkg::SIZE_W;
    localparam int DW    = cas_pkg::SHIFT_W;
    localparam int VW    = SW + 1;   // signed shifted coordinate

    // configuration
    logic [SW-1:0]        frame_width_reg, frame_height_reg;
    logic signed [DW-1:0] red_dx_reg, red_dy_reg, blue_dx_reg, blue_dy_reg;
    logic                 has_alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= cas_pkg::RST_FRAME_WIDTH;
            frame_height_reg <= cas_pkg::RST_FRAME_HEIGHT;
            red_dx_reg       <= cas_pkg::RST_RED_DX;
            red_dy_reg       <= cas_pkg::RST_RED_DY;
            blue_dx_reg      <= cas_pkg::RST_BLUE_DX;
            blue_dy_reg      <= cas_pkg::RST_BLUE_DY;
            has_alpha_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cas_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[SW-1:0];
                cas_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[SW-1:0];
                cas_pkg::CFG_RED_DX:       red_dx_reg       <= cfg_data[DW-1:0];
                cas_pkg::CFG_RED_DY:       red_dy_reg       <= cfg_data[DW-1:0];
                cas_pkg::CFG_BLUE_DX:      blue_dx_reg      <= cfg_data[DW-1:0];
                cas_pkg::CFG_BLUE_DY:      blue_dy_reg      <= cfg_data[DW-1:0];
                cas_pkg::CFG_HAS_ALPHA:    has_alpha_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // active frame size, saturated to 1..MAX
    logic [SW-1:0] act_w, act_h;

    always_comb
    begin
        if (frame_width_reg == '0)
            act_w = SW'(1);
        else if (int'(frame_width_reg) > MAX_WIDTH)
            act_w = SW'(MAX_WIDTH);
        else
            act_w = frame_width_reg;

        if (frame_height_reg == '0)
            act_h = SW'(1);
        else if (int'(frame_height_reg) > MAX_HEIGHT)
            act_h = SW'(MAX_HEIGHT);
        else
            act_h = frame_height_reg;
    end

    function automatic logic [SW-1:0] clamp_coord(input logic signed [VW-1:0] v,
                                                  input logic [SW-1:0] size);
        logic [SW-1:0] res;
        if (v < 0)
            res = '0;
        else if (v >= $signed({1'b0, size}))
            res = size - SW'(1);
        else
            res = v[SW-1:0];
        return res;
    endfunction

    // fetch position
    logic [PW-1:0] col_reg, row_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            col_reg <= col;
            row_reg <= row;
        end
    end

    logic signed [VW-1:0] pos_x, pos_y;

    assign pos_x = $signed({2'b00, col_reg});
    assign pos_y = $signed({2'b00, row_reg});

    // clamped sample coordinates
    logic [SW-1:0] rx_reg, ry_reg, gx_reg, gy_reg, bx_reg, by_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.clamp)
        begin
            rx_reg <= clamp_coord(pos_x - VW'(red_dx_reg), act_w);
            ry_reg <= clamp_coord(pos_y - VW'(red_dy_reg), act_h);
            gx_reg <= clamp_coord(pos_x, act_w);
            gy_reg <= clamp_coord(pos_y, act_h);
            bx_reg <= clamp_coord(pos_x - VW'(blue_dx_reg), act_w);
            by_reg <= clamp_coord(pos_y - VW'(blue_dy_reg), act_h);
        end
    end

    // read addresses, row major
    logic [AW-1:0] raddr_reg, gaddr_reg, baddr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.addr)
        begin
            raddr_reg <= AW'(ry_reg) * AW'(MAX_WIDTH) + AW'(rx_reg);
            gaddr_reg <= AW'(gy_reg) * AW'(MAX_WIDTH) + AW'(gx_reg);
            baddr_reg <= AW'(by_reg) * AW'(MAX_WIDTH) + AW'(bx_reg);
        end
    end

    // Three frame copies, each holding only the channels sampled from it
    logic [PW-1:0]   red_mem  [DEPTH];
    logic [2*PW-1:0] ga_mem   [DEPTH];
    logic [PW-1:0]   blue_mem [DEPTH];
    logic [AW-1:0]   waddr;
    logic            store_ok;
    logic [PW-1:0]   red_rd_reg, blue_rd_reg;
    logic [2*PW-1:0] ga_rd_reg;

    assign store_ok = (int'(col) < MAX_WIDTH) && (int'(row) < MAX_HEIGHT);
    assign waddr    = AW'(row) * AW'(MAX_WIDTH) + AW'(col);

    always_ff @(posedge clk)
    begin
        if (cmd.store && store_ok)
        begin
            red_mem[waddr]  <= in_red;
            ga_mem[waddr]   <= {in_alpha, in_green};
            blue_mem[waddr] <= in_blue;
        end
        if (cmd.read)
        begin
            red_rd_reg  <= red_mem[raddr_reg];
            ga_rd_reg   <= ga_mem[gaddr_reg];
            blue_rd_reg <= blue_mem[baddr_reg];
        end
    end

    // output register
    logic [PW-1:0] out_col_reg, out_row_reg, out_red_reg, out_green_reg;
    logic [PW-1:0] out_blue_reg, out_alpha_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_col_reg   <= col_reg;
            out_row_reg   <= row_reg;
            out_red_reg   <= red_rd_reg;
            out_green_reg <= ga_rd_reg[PW-1:0];
            out_blue_reg  <= blue_rd_reg;
            out_alpha_reg <= has_alpha_reg ? ga_rd_reg[2*PW-1:PW] : '0;
        end
    end

    assign out_col   = out_col_reg;
    assign out_row   = out_row_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;
    assign out_alpha = out_alpha_reg;

endmodule
